// File: rtl/core/char_lcd_nibble_sequencer_assert.svh
// Assertion macros shared by the character LCD nibble sequencer RTL.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define CLNS_ASSERT_IMP(lbl, clock, reset, ante, cons) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("clns assertion failed");

// Next-cycle implication, checked outside reset.
`define CLNS_ASSERT_NXT(lbl, clock, reset, ante, cons) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("clns assertion failed");

`else

`define CLNS_ASSERT_IMP(lbl, clock, reset, ante, cons)
`define CLNS_ASSERT_NXT(lbl, clock, reset, ante, cons)

`endif

`endif

// File: rtl/core/clns_pkg.sv
// Types, constants and tables shared by the character LCD nibble sequencer.
package clns_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Wake-up nibbles plus the four init command bytes, two nibbles each.
  localparam int unsigned PU_NIBBLES = 12;
  localparam int unsigned NIDX_W     = $clog2(PU_NIBBLES);

  localparam logic [15:0] RST_POWERUP_WAIT = 16'd20000;
  localparam logic [15:0] RST_FIRST_WAKE   = 16'd5000;
  localparam logic [15:0] RST_LONG_CMD     = 16'd2000;
  localparam logic [15:0] RST_SHORT        = 16'd1000;

  typedef enum logic [1:0] {
    MODE_CMD      = 2'd0,
    MODE_DATA     = 2'd1,
    MODE_POWERUP  = 2'd2,
    MODE_RESERVED = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_POWERUP_WAIT = 2'd0,
    CFG_FIRST_WAKE   = 2'd1,
    CFG_LONG_CMD     = 2'd2,
    CFG_SHORT        = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_FIRST,
    WAIT_SHORT,
    WAIT_LONG
  } wait_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_OPEN,
    SEQ_NIBBLE
  } seq_state_t;

  typedef struct packed {
    logic       powerup;
    logic       rs;
    logic [7:0] byte_val;
  } job_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } queue_status_t;

  typedef struct packed {
    logic [3:0] nib;
    wait_t      wait_kind;
  } pu_entry_t;

  // Power-up nibble table: 3,3,3,2 wake-up, then 0x28, 0x06, 0x01, 0x0F.
  function automatic pu_entry_t pu_nibble(input logic [NIDX_W-1:0] idx);
    pu_entry_t e;
    case (idx)
      4'd0:    e = '{nib: 4'h3, wait_kind: WAIT_FIRST};
      4'd1:    e = '{nib: 4'h3, wait_kind: WAIT_SHORT};
      4'd2:    e = '{nib: 4'h3, wait_kind: WAIT_SHORT};
      4'd3:    e = '{nib: 4'h2, wait_kind: WAIT_SHORT};
      4'd4:    e = '{nib: 4'h2, wait_kind: WAIT_NONE};
      4'd5:    e = '{nib: 4'h8, wait_kind: WAIT_SHORT};
      4'd6:    e = '{nib: 4'h0, wait_kind: WAIT_NONE};
      4'd7:    e = '{nib: 4'h6, wait_kind: WAIT_SHORT};
      4'd8:    e = '{nib: 4'h0, wait_kind: WAIT_NONE};
      4'd9:    e = '{nib: 4'h1, wait_kind: WAIT_LONG};
      4'd10:   e = '{nib: 4'h0, wait_kind: WAIT_NONE};
      4'd11:   e = '{nib: 4'hF, wait_kind: WAIT_SHORT};
      default: e = '{nib: 4'h0, wait_kind: WAIT_NONE};
    endcase
    return e;
  endfunction

endpackage

// File: rtl/core/clns_front.sv
// Request front end: accept requests, classify them and push jobs.
module clns_front (
  input  logic                   req_valid,
  output logic                   req_stall,
  input  logic [1:0]             mode,
  input  logic [7:0]             byte_value,
  input  clns_pkg::queue_status_t q_status,
  output logic                   push,
  output clns_pkg::job_t         push_job
);

  logic accept;

  assign req_stall = q_status.full;
  assign accept    = req_valid && !q_status.full;

  always_comb begin
    push_job.byte_val = byte_value;
    push_job.rs       = 1'b0;
    push_job.powerup  = 1'b0;
    push              = 1'b0;
    case (clns_pkg::mode_t'(mode))
      clns_pkg::MODE_CMD: begin
        push = accept;
      end
      clns_pkg::MODE_DATA: begin
        push_job.rs = 1'b1;
        push        = accept;
      end
      clns_pkg::MODE_POWERUP: begin
        push_job.powerup = 1'b1;
        push             = accept;
      end
      default: begin
        // drop reserved requests: transfer completes, nothing is queued
        push = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/core/clns_queue.sv
// Short job queue between the front end and the pin sequencer.
module clns_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  clns_pkg::job_t          push_job,
  input  logic                    pop,
  output clns_pkg::job_t          head,
  output clns_pkg::queue_status_t status
);

  clns_pkg::job_t                 entries [clns_pkg::QUEUE_DEPTH];
  logic [clns_pkg::QPTR_W-1:0]    wr_ptr;
  logic [clns_pkg::QPTR_W-1:0]    rd_ptr;
  logic [clns_pkg::QCNT_W-1:0]    count;

  function automatic logic [clns_pkg::QPTR_W-1:0] bump(
    input logic [clns_pkg::QPTR_W-1:0] p
  );
    logic [clns_pkg::QPTR_W-1:0] r;
    if (p == clns_pkg::QPTR_W'(clns_pkg::QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign head             = entries[rd_ptr];
  assign status.not_empty = (count != '0);
  assign status.full      = (count == clns_pkg::QCNT_W'(clns_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/clns_back.sv
// Pin sequencer: expand queued jobs into pin states, hold the wait registers.
`include "char_lcd_nibble_sequencer_assert.svh"

module clns_back (
  input  logic                    clk,
  input  logic                    rst,
  input  clns_pkg::job_t          head,
  input  clns_pkg::queue_status_t q_status,
  output logic                    pop,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [15:0]             cfg_data,
  output logic                    pin_valid,
  input  logic                    pin_stall,
  output logic                    reg_select,
  output logic                    enable_line,
  output logic [3:0]              data_nibble,
  output logic [15:0]             hold_us,
  output logic                    last
);

  logic [15:0] powerup_wait;
  logic [15:0] first_wake_wait;
  logic [15:0] long_cmd_wait;
  logic [15:0] short_wait;

  clns_pkg::seq_state_t          state;
  clns_pkg::seq_state_t          state_next;
  logic [clns_pkg::NIDX_W-1:0]   nib_idx;
  logic [clns_pkg::NIDX_W-1:0]   nib_idx_next;
  logic [1:0]                    phase;
  logic [1:0]                    phase_next;
  clns_pkg::job_t                job;

  logic                          advance;
  logic                          gen_rs;
  logic                          gen_en;
  logic [3:0]                    gen_nib;
  logic [15:0]                   gen_hold;
  logic                          gen_last;
  clns_pkg::wait_t               gen_wait;
  clns_pkg::pu_entry_t           pu_e;

  // Config registers; writes always land.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      powerup_wait    <= clns_pkg::RST_POWERUP_WAIT;
      first_wake_wait <= clns_pkg::RST_FIRST_WAKE;
      long_cmd_wait   <= clns_pkg::RST_LONG_CMD;
      short_wait      <= clns_pkg::RST_SHORT;
    end else if (cfg_valid) begin
      case (clns_pkg::cfg_reg_t'(cfg_index))
        clns_pkg::CFG_POWERUP_WAIT: powerup_wait    <= cfg_data;
        clns_pkg::CFG_FIRST_WAKE:   first_wake_wait <= cfg_data;
        clns_pkg::CFG_LONG_CMD:     long_cmd_wait   <= cfg_data;
        clns_pkg::CFG_SHORT:        short_wait      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Output register is free when empty or being taken this cycle.
  assign advance = !pin_valid || !pin_stall;

  // Pin state generator.
  always_comb begin
    pu_e     = clns_pkg::pu_nibble(nib_idx);
    gen_rs   = job.rs;
    gen_en   = (phase == 2'd1);
    gen_nib  = 4'h0;
    gen_wait = clns_pkg::WAIT_NONE;
    gen_last = 1'b0;
    gen_hold = 16'd0;
    case (state)
      clns_pkg::SEQ_OPEN: begin
        gen_rs   = 1'b0;
        gen_en   = 1'b0;
        gen_hold = powerup_wait;
      end
      clns_pkg::SEQ_NIBBLE: begin
        if (job.powerup) begin
          gen_nib  = pu_e.nib;
          gen_wait = pu_e.wait_kind;
          gen_last = (nib_idx == clns_pkg::NIDX_W'(clns_pkg::PU_NIBBLES - 1)) &&
                     (phase == 2'd2);
        end else begin
          gen_nib  = nib_idx[0] ? job.byte_val[3:0] : job.byte_val[7:4];
          if (nib_idx[0]) begin
            gen_wait = (!job.rs && job.byte_val[7:2] == 6'd0) ?
                       clns_pkg::WAIT_LONG : clns_pkg::WAIT_SHORT;
          end
          gen_last = nib_idx[0] && (phase == 2'd2);
        end
        if (phase == 2'd2) begin
          case (gen_wait)
            clns_pkg::WAIT_FIRST: gen_hold = first_wake_wait;
            clns_pkg::WAIT_SHORT: gen_hold = short_wait;
            clns_pkg::WAIT_LONG:  gen_hold = long_cmd_wait;
            default:              gen_hold = 16'd0;
          endcase
        end
      end
      default: begin
        gen_rs = 1'b0;
        gen_en = 1'b0;
      end
    endcase
  end

  // Next state: step through nibbles and phases, take a new job at the end.
  always_comb begin
    state_next   = state;
    nib_idx_next = nib_idx;
    phase_next   = phase;
    pop          = 1'b0;
    case (state)
      clns_pkg::SEQ_IDLE: begin
        pop = q_status.not_empty;
      end
      clns_pkg::SEQ_OPEN: begin
        if (advance) begin
          state_next   = clns_pkg::SEQ_NIBBLE;
          nib_idx_next = '0;
          phase_next   = 2'd0;
        end
      end
      clns_pkg::SEQ_NIBBLE: begin
        if (advance) begin
          if (gen_last) begin
            pop        = q_status.not_empty;
            state_next = clns_pkg::SEQ_IDLE;
          end else if (phase == 2'd2) begin
            nib_idx_next = nib_idx + 1'b1;
            phase_next   = 2'd0;
          end else begin
            phase_next = phase + 1'b1;
          end
        end
      end
      default: begin
        state_next = clns_pkg::SEQ_IDLE;
      end
    endcase
    if (pop) begin
      state_next   = head.powerup ? clns_pkg::SEQ_OPEN : clns_pkg::SEQ_NIBBLE;
      nib_idx_next = '0;
      phase_next   = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= clns_pkg::SEQ_IDLE;
      nib_idx <= '0;
      phase   <= 2'd0;
    end else begin
      state   <= state_next;
      nib_idx <= nib_idx_next;
      phase   <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pin_valid <= 1'b0;
    end else if (advance) begin
      pin_valid <= (state != clns_pkg::SEQ_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (advance && state != clns_pkg::SEQ_IDLE) begin
      reg_select  <= gen_rs;
      enable_line <= gen_en;
      data_nibble <= gen_nib;
      hold_us     <= gen_hold;
      last        <= gen_last;
    end
  end

  `CLNS_ASSERT_IMP(a_pop_nonempty, clk, rst, pop, q_status.not_empty)
  `CLNS_ASSERT_IMP(a_open_is_powerup, clk, rst, state == clns_pkg::SEQ_OPEN, job.powerup)
  `CLNS_ASSERT_IMP(a_strobe_no_hold, clk, rst, pin_valid && enable_line, hold_us == 16'd0 && !last)
  `CLNS_ASSERT_IMP(a_byte_two_nibbles, clk, rst, state == clns_pkg::SEQ_NIBBLE && !job.powerup, nib_idx <= clns_pkg::NIDX_W'(1))
  `CLNS_ASSERT_NXT(a_last_ends_job, clk, rst, advance && gen_last && !q_status.not_empty, state == clns_pkg::SEQ_IDLE)

endmodule

// File: rtl/core/char_lcd_nibble_sequencer.sv
// Top level of the character LCD 4-bit nibble sequencer.
//
// Request channel (req_valid / req_stall, mode, byte_value): a transfer asks for a
// command byte (mode 0), a data byte (mode 1) or the power-up sequence (mode 2).
// Mode 3 is taken and dropped without any pin state.
// Pin channel (pin_valid / pin_stall): each transfer is one pin state - register
// select, enable level, data nibble and the hold time in microseconds - with last
// set on the final state of the request. A byte gives six states (high nibble
// first, three states per nibble); power-up gives thirty-seven.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data) loads the four wait
// registers; cfg_ready is always high. Write only while the block is idle.
// A request passes the job queue, the sequencer state and the output register.
// Throughput: one pin state per cycle while pin_stall is low, set by the pin
// sequencer stepping one state per cycle; back-to-back requests follow with
// no gap through the two-entry job queue.
// Reset clears the queue and sequencer and loads the default waits.
// A stalled pin channel holds the output register; the queue keeps taking
// requests until it is full, then raises req_stall.
module char_lcd_nibble_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  byte_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        pin_valid,
  input  logic        pin_stall,
  output logic        reg_select,
  output logic        enable_line,
  output logic [3:0]  data_nibble,
  output logic [15:0] hold_us,
  output logic        last
);

  clns_pkg::queue_status_t q_status;
  clns_pkg::job_t          push_job;
  clns_pkg::job_t          head;
  logic                    push;
  logic                    pop;

  // Front end: classify the request and push a job.
  clns_front u_front (
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .mode       (mode),
    .byte_value (byte_value),
    .q_status   (q_status),
    .push       (push),
    .push_job   (push_job)
  );

  // Job queue decouples the request side from pin-side stalls.
  clns_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // Back end: expand jobs into pin states through the output register.
  clns_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_status    (q_status),
    .pop         (pop),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pin_valid   (pin_valid),
    .pin_stall   (pin_stall),
    .reg_select  (reg_select),
    .enable_line (enable_line),
    .data_nibble (data_nibble),
    .hold_us     (hold_us),
    .last        (last)
  );

endmodule
